// File: rtl/sphk_pkg.sv
// sphk_pkg: constants, tag structs and the output clamp for the sph cubic kernel block
// used by sph_cubic_kernel_and_gradient and tb_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sphk_pkg;

    // 5/(14*pi) in Q0.32
    localparam logic [28:0] KERNEL_K = 29'd488260911;
    localparam logic [23:0] H_RESET  = 24'd65536;
    localparam int          SQRT_IW  = 52;

    // tag through the square root
    typedef struct packed {
        logic        bad;
        logic        far;
        logic        xneg;
        logic        yneg;
        logic [24:0] adx;
        logic [24:0] ady;
    } sqrt_tag_t;

    // tag through the q and unit-vector dividers
    typedef struct packed {
        logic bad;
        logic far;
        logic xneg;
        logic yneg;
        logic xzero;
        logic yzero;
    } qdiv_tag_t;

    // tag through the kernel divider
    typedef struct packed {
        logic        bad;
        logic        kzero;
        logic        gzx;
        logic        gzy;
        logic        xneg;
        logic        yneg;
        logic        gneg;
        logic [31:0] mx;
        logic [31:0] my;
    } wdiv_tag_t;

    // tag through the h^2 gradient dividers
    typedef struct packed {
        logic        bad;
        logic        gzx;
        logic        gzy;
        logic        xneg;
        logic        yneg;
        logic [31:0] w;
    } xdiv_tag_t;

    // tag through the final 1/h dividers
    typedef struct packed {
        logic        bad;
        logic        gzx;
        logic        gzy;
        logic        xneg;
        logic        yneg;
        logic        xsat;
        logic        ysat;
        logic [31:0] w;
    } mdiv_tag_t;

    function automatic logic [31:0] grad_clamp(input logic [31:0] mag, input logic sat,
                                               input logic neg, input logic zero);
        logic [31:0] r;
        if (zero) begin
            r = '0;
        end else if (neg) begin
            r = (sat || mag > 32'h8000_0000) ? 32'h8000_0000 : (~mag + 32'd1);
        end else begin
            r = (sat || mag[31]) ? 32'h7FFF_FFFF : mag;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sphk_sqrt.sv
// sphk_sqrt: pipelined floor square root, one result bit per stage, tag carried along
// depends on nothing; used by sph_cubic_kernel_and_gradient
`timescale 1ns / 1ps
`default_nettype none

module sphk_sqrt #(
    parameter int IW = 52,
    parameter int TW = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [IW-1:0]     in_x,
    input  wire logic [TW-1:0]     in_tag,
    output logic                   out_valid,
    output logic [IW/2-1:0]        out_root,
    output logic [TW-1:0]          out_tag
);

    localparam int RTW = IW / 2;

    logic [RTW:0]   vld_reg;
    logic [IW-1:0]  x_reg    [RTW];
    logic [RTW:0]   rem_reg  [RTW];
    logic [RTW-1:0] root_reg [RTW+1];
    logic [TW-1:0]  tag_reg  [RTW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[RTW-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= in_x;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            tag_reg[0]  <= in_tag;
        end
    end

    for (genvar k = 1; k <= RTW; k++) begin : g_step
        logic [RTW+2:0] rem2;
        logic [RTW+2:0] trial;
        logic [RTW+2:0] diff;
        logic           take;

        assign rem2  = {rem_reg[k-1], x_reg[k-1][IW-1:IW-2]};
        assign trial = (RTW+3)'({root_reg[k-1], 2'b01});
        assign take  = rem2 >= trial;
        assign diff  = rem2 - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_reg[k-1][RTW-2:0], take};
                tag_reg[k]  <= tag_reg[k-1];
            end
        end

        if (k < RTW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? diff[RTW:0] : rem2[RTW:0];
                    x_reg[k]   <= {x_reg[k-1][IW-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = vld_reg[RTW];
    assign out_root  = root_reg[RTW];
    assign out_tag   = tag_reg[RTW];

endmodule

`default_nettype wire

// File: rtl/sphk_div.sv
// sphk_div: pipelined restoring divider, one quotient bit per stage, overflow flag, tag
// depends on nothing; used by sph_cubic_kernel_and_gradient
`timescale 1ns / 1ps
`default_nettype none

module sphk_div #(
    parameter int DW  = 24,
    parameter int QW  = 32,
    parameter int NHW = 24,
    parameter int TW  = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [NHW-1:0] in_nhi,
    input  wire logic [QW-1:0]  in_nlo,
    input  wire logic [DW-1:0]  in_d,
    input  wire logic [TW-1:0]  in_tag,
    output logic                out_valid,
    output logic [QW-1:0]       out_quot,
    output logic                out_ovf,
    output logic [TW-1:0]       out_tag
);

    localparam int CW = (NHW > DW) ? NHW : DW;

    logic [QW:0]    vld_reg;
    logic [DW-1:0]  rem_reg [QW];
    logic [DW-1:0]  d_reg   [QW];
    logic [QW-1:0]  nq_reg  [QW+1];
    logic [QW:0]    ovf_reg;
    logic [TW-1:0]  tag_reg [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-1:0], in_valid};
        end
    end

    // quotient too wide for QW bits when the high part already reaches the divisor
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= DW'(in_nhi);
            d_reg[0]   <= in_d;
            nq_reg[0]  <= in_nlo;
            ovf_reg[0] <= CW'(in_nhi) >= CW'(in_d);
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        take;

        assign trial = {rem_reg[k-1], nq_reg[k-1][QW-1]};
        assign take  = trial >= {1'b0, d_reg[k-1]};
        assign diff  = trial - {1'b0, d_reg[k-1]};

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg[k]  <= {nq_reg[k-1][QW-2:0], take};
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
                    d_reg[k]   <= d_reg[k-1];
                end
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quot  = nq_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_tag   = tag_reg[QW];

endmodule

`default_nettype wire

// File: rtl/sph_cubic_kernel_and_gradient.sv
// sph_cubic_kernel_and_gradient: 2D cubic spline SPH kernel weight and gradient per pair
// depends on sphk_pkg, sphk_sqrt and sphk_div
//
// Usage: s_valid/s_ready carry one particle pair (Q16.16 positions) per transfer,
// m_valid/m_ready return kernel_value, grad_x, grad_y and bad_length per transfer.
// cfg_wr_en/cfg_wr_data write the smoothing length h (Q8.16); write only while idle.
// The pipeline has 189 register stages: 3 front stages, a 27-stage square root,
// a 32-stage q divider, 5 polynomial/multiply stages, then three chained divider
// pipelines of 33, 55 and 33 stages and the output register. It takes one pair per
// cycle while the receiver does not stall; each divider or root stage after its input
// register gives one quotient or root bit. When the receiver stalls with a result held,
// the whole pipeline freezes and s_ready drops; nothing is lost or repeated. Reset
// clears all valid bits and sets h to 1.0; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module sph_cubic_kernel_and_gradient (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [23:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_pos_i_x,
    input  wire logic signed [31:0] s_pos_i_y,
    input  wire logic signed [31:0] s_pos_j_x,
    input  wire logic signed [31:0] s_pos_j_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_kernel_value,
    output logic signed [31:0]      m_grad_x,
    output logic signed [31:0]      m_grad_y,
    output logic                    m_bad_length
);

    logic [23:0] h_reg;
    logic [47:0] hsq_reg;
    logic        en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg <= sphk_pkg::H_RESET;
        end else if (cfg_wr_en) begin
            h_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        hsq_reg <= 48'(h_reg) * 48'(h_reg);
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // front: offsets, magnitudes, squares, sum
    logic [32:0] dx, dy, adxf, adyf;
    assign dx   = {s_pos_i_x[31], s_pos_i_x} - {s_pos_j_x[31], s_pos_j_x};
    assign dy   = {s_pos_i_y[31], s_pos_i_y} - {s_pos_j_y[31], s_pos_j_y};
    assign adxf = dx[32] ? (~dx + 33'd1) : dx;
    assign adyf = dy[32] ? (~dy + 33'd1) : dy;

    logic                v1_reg, v2_reg, v3_reg;
    sphk_pkg::sqrt_tag_t t1_reg, t2_reg, t3_reg;
    logic [49:0]         sqx_reg, sqy_reg;
    logic [50:0]         sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg.bad  <= h_reg == 24'd0;
            t1_reg.far  <= (|adxf[32:25]) || (|adyf[32:25]);
            t1_reg.xneg <= dx[32];
            t1_reg.yneg <= dy[32];
            t1_reg.adx  <= adxf[24:0];
            t1_reg.ady  <= adyf[24:0];
            t2_reg      <= t1_reg;
            sqx_reg     <= 50'(t1_reg.adx) * 50'(t1_reg.adx);
            sqy_reg     <= 50'(t1_reg.ady) * 50'(t1_reg.ady);
            t3_reg      <= t2_reg;
            sum_reg     <= 51'(sqx_reg) + 51'(sqy_reg);
        end
    end

    // distance
    logic                sq_valid;
    logic [25:0]         root_len;
    logic [$bits(sphk_pkg::sqrt_tag_t)-1:0] sq_tag_bits;
    sphk_pkg::sqrt_tag_t sq_tag;

    sphk_sqrt #(
        .IW (sphk_pkg::SQRT_IW),
        .TW ($bits(sphk_pkg::sqrt_tag_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_x      ({1'b0, sum_reg}),
        .in_tag    (t3_reg),
        .out_valid (sq_valid),
        .out_root  (root_len),
        .out_tag   (sq_tag_bits)
    );
    assign sq_tag = sq_tag_bits;

    // q = distance/h in Q1.30, unit vector components ad/distance in Q1.30
    sphk_pkg::qdiv_tag_t qd_in_tag, qd_tag;
    logic [$bits(sphk_pkg::qdiv_tag_t)-1:0] qd_tag_bits;
    logic        qd_valid, ux_valid, uy_valid;
    logic [30:0] q, ux, uy;
    logic        q_far, ux_ovf, uy_ovf;

    assign qd_in_tag.bad   = sq_tag.bad;
    assign qd_in_tag.far   = sq_tag.far;
    assign qd_in_tag.xneg  = sq_tag.xneg;
    assign qd_in_tag.yneg  = sq_tag.yneg;
    assign qd_in_tag.xzero = sq_tag.adx == 25'd0;
    assign qd_in_tag.yzero = sq_tag.ady == 25'd0;

    sphk_div #(.DW(24), .QW(31), .NHW(25), .TW($bits(sphk_pkg::qdiv_tag_t))) u_qdiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (sq_valid), .in_nhi (root_len[25:1]), .in_nlo ({root_len[0], 30'd0}),
        .in_d (h_reg), .in_tag (qd_in_tag),
        .out_valid (qd_valid), .out_quot (q), .out_ovf (q_far), .out_tag (qd_tag_bits)
    );
    assign qd_tag = qd_tag_bits;

    sphk_div #(.DW(26), .QW(31), .NHW(24), .TW(1)) u_uxdiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (sq_valid), .in_nhi (sq_tag.adx[24:1]), .in_nlo ({sq_tag.adx[0], 30'd0}),
        .in_d (root_len), .in_tag (1'b0),
        .out_valid (ux_valid), .out_quot (ux), .out_ovf (ux_ovf), .out_tag ()
    );

    sphk_div #(.DW(26), .QW(31), .NHW(24), .TW(1)) u_uydiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (sq_valid), .in_nhi (sq_tag.ady[24:1]), .in_nlo ({sq_tag.ady[0], 30'd0}),
        .in_d (root_len), .in_tag (1'b0),
        .out_valid (uy_valid), .out_quot (uy), .out_ovf (uy_ovf), .out_tag ()
    );

    // polynomial stages
    logic        v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic        bad5_reg, kz5_reg, gzx5_reg, gzy5_reg, xn5_reg, yn5_reg;
    logic        bad6_reg, kz6_reg, gzx6_reg, gzy6_reg, xn6_reg, yn6_reg;
    logic        bad7_reg, kz7_reg, gzx7_reg, gzy7_reg, xn7_reg, yn7_reg, gn7_reg;
    logic        bad8_reg, kz8_reg, gzx8_reg, gzy8_reg, xn8_reg, yn8_reg, gn8_reg;
    logic [30:0] t1_5_reg, t1_6_reg, s1_6_reg, c1_7_reg;
    logic [31:0] t2_5_reg, t2_6_reg;
    logic [32:0] s2_6_reg;
    logic [33:0] c2_7_reg, p8_reg;
    logic [34:0] ag7_reg;
    logic [31:0] a8_reg;
    logic [30:0] ux5_reg, uy5_reg, ux6_reg, uy6_reg, ux7_reg, uy7_reg, ux8_reg, uy8_reg;
    logic [48:0] wn9_reg;
    sphk_pkg::wdiv_tag_t wd_in_reg;

    logic [61:0] t1sq, s1t1;
    logic [63:0] t2sq, agk;
    logic [64:0] s2t2;
    logic [35:0] g12, g3;
    logic [32:0] c1x4;
    logic [62:0] kp, axu, ayu;

    assign t1sq = 62'(t1_5_reg) * 62'(t1_5_reg);
    assign t2sq = 64'(t2_5_reg) * 64'(t2_5_reg);
    assign s1t1 = 62'(s1_6_reg) * 62'(t1_6_reg);
    assign s2t2 = 65'(s2_6_reg) * 65'(t2_6_reg);
    assign g12  = {2'b00, s1_6_reg, 3'b000} + {3'b000, s1_6_reg, 2'b00};
    assign g3   = {2'b00, s2_6_reg, 1'b0} + {3'b000, s2_6_reg};
    assign c1x4 = {c1_7_reg, 2'b00};
    assign agk  = 64'(ag7_reg) * 64'(sphk_pkg::KERNEL_K);
    assign kp   = 63'(p8_reg) * 63'(sphk_pkg::KERNEL_K);
    assign axu  = 63'(a8_reg) * 63'(ux8_reg);
    assign ayu  = 63'(a8_reg) * 63'(uy8_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= qd_valid && ux_valid && uy_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // t1 = max(1-q,0), t2 = 2-q
            t1_5_reg <= q[30] ? 31'd0 : (31'h4000_0000 - q);
            t2_5_reg <= 32'h8000_0000 - {1'b0, q};
            bad5_reg <= qd_tag.bad;
            kz5_reg  <= qd_tag.bad || qd_tag.far || q_far;
            // the gradient also vanishes at coincident particles and on a zero axis
            gzx5_reg <= qd_tag.bad || qd_tag.far || q_far || q == 31'd0 || qd_tag.xzero
                        || ux_ovf;
            gzy5_reg <= qd_tag.bad || qd_tag.far || q_far || q == 31'd0 || qd_tag.yzero
                        || uy_ovf;
            xn5_reg  <= qd_tag.xneg;
            yn5_reg  <= qd_tag.yneg;
            ux5_reg  <= ux;
            uy5_reg  <= uy;

            s1_6_reg <= t1sq[60:30];
            s2_6_reg <= t2sq[62:30];
            t1_6_reg <= t1_5_reg;
            t2_6_reg <= t2_5_reg;
            {bad6_reg, kz6_reg, gzx6_reg, gzy6_reg, xn6_reg, yn6_reg} <=
                {bad5_reg, kz5_reg, gzx5_reg, gzy5_reg, xn5_reg, yn5_reg};
            ux6_reg  <= ux5_reg;
            uy6_reg  <= uy5_reg;

            c1_7_reg <= s1t1[60:30];
            c2_7_reg <= s2t2[63:30];
            gn7_reg  <= g12 < g3;
            ag7_reg  <= (g12 < g3) ? 35'(g3 - g12) : 35'(g12 - g3);
            {bad7_reg, kz7_reg, gzx7_reg, gzy7_reg, xn7_reg, yn7_reg} <=
                {bad6_reg, kz6_reg, gzx6_reg, gzy6_reg, xn6_reg, yn6_reg};
            ux7_reg  <= ux6_reg;
            uy7_reg  <= uy6_reg;

            p8_reg   <= (c2_7_reg > 34'(c1x4)) ? (c2_7_reg - 34'(c1x4)) : 34'd0;
            a8_reg   <= agk[63:32];
            {bad8_reg, kz8_reg, gzx8_reg, gzy8_reg, xn8_reg, yn8_reg, gn8_reg} <=
                {bad7_reg, kz7_reg, gzx7_reg, gzy7_reg, xn7_reg, yn7_reg, gn7_reg};
            ux8_reg  <= ux7_reg;
            uy8_reg  <= uy7_reg;

            wn9_reg         <= kp[62:14];
            wd_in_reg.bad   <= bad8_reg;
            wd_in_reg.kzero <= kz8_reg;
            wd_in_reg.gzx   <= gzx8_reg;
            wd_in_reg.gzy   <= gzy8_reg;
            wd_in_reg.xneg  <= xn8_reg;
            wd_in_reg.yneg  <= yn8_reg;
            wd_in_reg.gneg  <= gn8_reg;
            wd_in_reg.mx    <= axu[61:30];
            wd_in_reg.my    <= ayu[61:30];
        end
    end

    // kernel weight: W = (K*p >> 14) / h^2
    logic        wd_valid, w_ovf;
    logic [31:0] wq;
    logic [$bits(sphk_pkg::wdiv_tag_t)-1:0] wd_tag_bits;
    sphk_pkg::wdiv_tag_t wd_tag;

    sphk_div #(.DW(48), .QW(32), .NHW(17), .TW($bits(sphk_pkg::wdiv_tag_t))) u_wdiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (v9_reg), .in_nhi (wn9_reg[48:32]), .in_nlo (wn9_reg[31:0]),
        .in_d (hsq_reg), .in_tag (wd_in_reg),
        .out_valid (wd_valid), .out_quot (wq), .out_ovf (w_ovf), .out_tag (wd_tag_bits)
    );
    assign wd_tag = wd_tag_bits;

    // gradient: x = m*2^32 / h^2, clamped at 2^54
    sphk_pkg::xdiv_tag_t xd_in_tag, xd_tag;
    logic [$bits(sphk_pkg::xdiv_tag_t)-1:0] xd_tag_bits;
    logic        xdx_valid, xdy_valid, xx_ovf, xy_ovf;
    logic [53:0] xx, xy;

    assign xd_in_tag.bad  = wd_tag.bad;
    assign xd_in_tag.gzx  = wd_tag.gzx;
    assign xd_in_tag.gzy  = wd_tag.gzy;
    assign xd_in_tag.xneg = wd_tag.xneg ^ wd_tag.gneg;
    assign xd_in_tag.yneg = wd_tag.yneg ^ wd_tag.gneg;
    assign xd_in_tag.w    = wd_tag.kzero ? 32'd0 : (w_ovf ? 32'hFFFF_FFFF : wq);

    sphk_div #(.DW(48), .QW(54), .NHW(10), .TW($bits(sphk_pkg::xdiv_tag_t))) u_xxdiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (wd_valid), .in_nhi (wd_tag.mx[31:22]), .in_nlo ({wd_tag.mx[21:0], 32'd0}),
        .in_d (hsq_reg), .in_tag (xd_in_tag),
        .out_valid (xdx_valid), .out_quot (xx), .out_ovf (xx_ovf), .out_tag (xd_tag_bits)
    );
    assign xd_tag = xd_tag_bits;

    sphk_div #(.DW(48), .QW(54), .NHW(10), .TW(1)) u_xydiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (wd_valid), .in_nhi (wd_tag.my[31:22]), .in_nlo ({wd_tag.my[21:0], 32'd0}),
        .in_d (hsq_reg), .in_tag (1'b0),
        .out_valid (xdy_valid), .out_quot (xy), .out_ovf (xy_ovf), .out_tag ()
    );

    // magnitude = 4x / h
    sphk_pkg::mdiv_tag_t md_in_tag, md_tag;
    logic [$bits(sphk_pkg::mdiv_tag_t)-1:0] md_tag_bits;
    logic        mdx_valid, mdy_valid, mx_ovf, my_ovf;
    logic [31:0] magx, magy;

    assign md_in_tag.bad  = xd_tag.bad;
    assign md_in_tag.gzx  = xd_tag.gzx;
    assign md_in_tag.gzy  = xd_tag.gzy;
    assign md_in_tag.xneg = xd_tag.xneg;
    assign md_in_tag.yneg = xd_tag.yneg;
    assign md_in_tag.xsat = xx_ovf;
    assign md_in_tag.ysat = xy_ovf;
    assign md_in_tag.w    = xd_tag.w;

    sphk_div #(.DW(24), .QW(32), .NHW(24), .TW($bits(sphk_pkg::mdiv_tag_t))) u_mxdiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (xdx_valid && xdy_valid), .in_nhi (xx[53:30]), .in_nlo ({xx[29:0], 2'b00}),
        .in_d (h_reg), .in_tag (md_in_tag),
        .out_valid (mdx_valid), .out_quot (magx), .out_ovf (mx_ovf), .out_tag (md_tag_bits)
    );
    assign md_tag = md_tag_bits;

    sphk_div #(.DW(24), .QW(32), .NHW(24), .TW(1)) u_mydiv (
        .aclk (aclk), .aresetn (aresetn), .en (en),
        .in_valid (xdx_valid && xdy_valid), .in_nhi (xy[53:30]), .in_nlo ({xy[29:0], 2'b00}),
        .in_d (h_reg), .in_tag (1'b0),
        .out_valid (mdy_valid), .out_quot (magy), .out_ovf (my_ovf), .out_tag ()
    );

    // output register
    logic        m_valid_reg;
    logic [31:0] kv_reg, gx_reg, gy_reg;
    logic        bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= mdx_valid && mdy_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kv_reg  <= md_tag.w;
            gx_reg  <= sphk_pkg::grad_clamp(magx, md_tag.xsat || mx_ovf, md_tag.xneg,
                                            md_tag.gzx);
            gy_reg  <= sphk_pkg::grad_clamp(magy, md_tag.ysat || my_ovf, md_tag.yneg,
                                            md_tag.gzy);
            bad_reg <= md_tag.bad;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kernel_value = kv_reg;
    assign m_grad_x       = gx_reg;
    assign m_grad_y       = gy_reg;
    assign m_bad_length   = bad_reg;

    // zero smoothing length forces every result field to zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_length |-> m_kernel_value == 32'd0 && m_grad_x == 32'sd0
                                    && m_grad_y == 32'sd0)
        else $error("bad_length result with nonzero fields");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted transfer did not enter the pipeline");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a held result");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// tb_top: testbench for sph_cubic_kernel_and_gradient, 2D cubic spline kernel and gradient
// depends on sphk_pkg and the rtl top; a scoreboard class predicts each pair in fixed point
`timescale 1ns / 1ps

class kernel_scoreboard;
    logic [23:0] h_len;
    logic [31:0] want_w[$];
    logic [31:0] want_gx[$];
    logic [31:0] want_gy[$];
    logic        want_bad[$];
    int          errors;

    function new();
        h_len  = sphk_pkg::H_RESET;
        errors = 0;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // one gradient component, signed Q16.16 with saturation
    function automatic logic [31:0] axis_grad(input logic [63:0] ad, input bit dneg,
                                              input logic [63:0] s, input logic [63:0] ag,
                                              input bit gneg, input logic [63:0] h);
        logic [63:0] u, a, m, x, mag;
        bit neg;
        neg = (dneg != gneg);
        if (ad == 0 || ag == 0) return 0;
        u = (ad << 30) / s;
        a = (ag * 64'd488260911) >> 32;
        m = (a * u) >> 30;
        x = (m << 32) / (h * h);
        if (x > (64'hFFFF_FFFF_FFFF_FFFF >> 2)) mag = 64'hFFFF_FFFF_FFFF_FFFF;
        else mag = (x * 4) / h;
        if (mag == 0) return 0;
        if (neg) begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            return 32'(64'h1_0000_0000 - mag);
        end
        if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function void add_expect(input logic [31:0] w, input logic [31:0] gx,
                             input logic [31:0] gy, input logic bad);
        want_w   = {want_w, w};
        want_gx  = {want_gx, gx};
        want_gy  = {want_gy, gy};
        want_bad = {want_bad, bad};
    endfunction

    function void note_pair(input logic [31:0] ix, input logic [31:0] iy,
                            input logic [31:0] jx, input logic [31:0] jy);
        logic [63:0] h, adx, ady, s, q, t1, t2, s1, s2, c1, c2, p, w, ag;
        longint dx, dy, g;
        logic [31:0] rw, rx, ry;
        h = {40'd0, h_len};
        rw = 0; rx = 0; ry = 0;
        if (h == 0) begin
            add_expect(0, 0, 0, 1);
            return;
        end
        dx = longint'($signed(ix)) - longint'($signed(jx));
        dy = longint'($signed(iy)) - longint'($signed(jy));
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx < (64'd1 << 25) && ady < (64'd1 << 25)) begin
            s = root64(adx * adx + ady * ady);
            q = (s << 30) / h;
            if (q < (64'd1 << 31)) begin
                t1 = q < (64'd1 << 30) ? (64'd1 << 30) - q : 0;
                t2 = (64'd1 << 31) - q;
                s1 = (t1 * t1) >> 30;
                s2 = (t2 * t2) >> 30;
                c1 = (s1 * t1) >> 30;
                c2 = (s2 * t2) >> 30;
                p = (c2 > 4 * c1) ? c2 - 4 * c1 : 0;
                w = (64'd488260911 * p) / ((h * h) << 14);
                rw = w > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : w[31:0];
                if (q != 0) begin
                    g = 12 * longint'(s1) - 3 * longint'(s2);
                    ag = g < 0 ? -g : g;
                    rx = axis_grad(adx, dx < 0, s, ag, g < 0, h);
                    ry = axis_grad(ady, dy < 0, s, ag, g < 0, h);
                end
            end
        end
        add_expect(rw, rx, ry, 0);
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    task check_result(input logic [31:0] w, input logic [31:0] gx,
                      input logic [31:0] gy, input logic bad);
        if (want_w.size() == 0) begin
            report("unexpected transfer", w, 0);
            return;
        end
        if (w !== want_w[0]) report("kernel_value", w, want_w[0]);
        if (gx !== want_gx[0]) report("grad_x", gx, want_gx[0]);
        if (gy !== want_gy[0]) report("grad_y", gy, want_gy[0]);
        if (bad !== want_bad[0]) report("bad_length", bad, want_bad[0]);
        void'(want_w.pop_front()); void'(want_gx.pop_front());
        void'(want_gy.pop_front()); void'(want_bad.pop_front());
    endtask
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [23:0] cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_pos_i_x = 0, s_pos_i_y = 0, s_pos_j_x = 0, s_pos_j_y = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_kernel_value;
    logic [31:0] m_grad_x, m_grad_y;
    logic        m_bad_length;

    kernel_scoreboard pair_sb = new();
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 0;
    int  quiet_cycles = 0;

    localparam int LATENCY = 189;
    localparam int QUIET_LIMIT = 20000;

    sph_cubic_kernel_and_gradient dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_i_x(s_pos_i_x), .s_pos_i_y(s_pos_i_y),
        .s_pos_j_x(s_pos_j_x), .s_pos_j_y(s_pos_j_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kernel_value(m_kernel_value), .m_grad_x(m_grad_x), .m_grad_y(m_grad_y),
        .m_bad_length(m_bad_length)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    // receiver: sample at rising edge, change ready at falling edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            pair_sb.check_result(m_kernel_value, m_grad_x, m_grad_y, m_bad_length);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge aclk) begin
        if (!aresetn || hold_off) m_ready <= 0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (quiet_cycles > QUIET_LIMIT) begin
            $display("sph_cubic_kernel_and_gradient test failed");
            $finish;
        end
    end

    // valid stays high between back-to-back transfers; idle cycles drop it
    task automatic send_pair(input logic [31:0] ix, input logic [31:0] iy,
                             input logic [31:0] jx, input logic [31:0] jy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_pos_i_x <= ix; s_pos_i_y <= iy; s_pos_j_x <= jx; s_pos_j_y <= jy;
        do @(posedge aclk); while (!s_ready);
        pair_sb.note_pair(ix, iy, jx, jy);
        @(negedge aclk);
    endtask

    task automatic drain;
        s_valid <= 0;
        while (pair_sb.want_w.size() != 0) @(negedge aclk);
    endtask

    task automatic set_length(input logic [23:0] h);
        drain();
        repeat (LATENCY + 5) @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= h;
        @(negedge aclk);
        cfg_wr_en <= 0;
        pair_sb.h_len = h;
    endtask

    // offset scaled to h so most pairs land inside the support
    task automatic random_pair(input logic [23:0] h);
        logic [31:0] ix, iy, jx, jy;
        int sel, span;
        sel = $urandom_range(9);
        ix = $urandom; iy = $urandom;
        span = (h == 0) ? 65536 : int'(h) * 2 + 2;
        if (sel < 7) begin
            jx = ix - ($urandom_range(span) - span / 2);
            jy = iy - ($urandom_range(span) - span / 2);
        end else if (sel < 9) begin
            jx = ix - ($urandom_range(32'h0400_0000) - 32'h0200_0000);
            jy = iy - ($urandom_range(32'h0400_0000) - 32'h0200_0000);
        end else begin
            jx = $urandom; jy = $urandom;
        end
        send_pair(ix, iy, jx, jy);
    endtask

    logic [23:0] lengths[6] = '{24'd65536, 24'hFF_FFFF, 24'd1, 24'd0, 24'd3000, 24'd200000};

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reset h = 1.0
        send_pair(0, 0, 0, 0);
        send_pair(32'h0000_8000, 0, 0, 0);
        send_pair(0, 32'h0001_8000, 0, 0);
        send_pair(32'h0000_4000, 32'h0000_4000, 32'h8000_0000, 0);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h01FF_FFFF, 0, 0, 0);
        send_pair(0, 0, 32'h0000_0001, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_C000, 32'h0000_2000, 0, 0);
        send_pair(32'h0002_0000, 0, 0, 0);
        set_length(1);
        send_pair(0, 0, 0, 0);
        send_pair(1, 0, 0, 0);
        send_pair(0, 32'hFFFF_FFFF, 0, 0);
        set_length(24'hFF_FFFF);
        send_pair(32'h0080_0000, 32'h0080_0000, 0, 0);
        send_pair(32'hFF00_0000, 0, 0, 0);
        set_length(0);
        send_pair(32'h1234_5678, 32'h9ABC_DEF0, 0, 32'h7FFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            set_length(lengths[ph]);
            if (ph < 2) begin send_idle_pct = 26; recv_idle_pct = 58; end
            else if (ph < 4) begin send_idle_pct = 58; recv_idle_pct = 26; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            if (ph == 4) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (600) @(negedge aclk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 340; n++) random_pair(lengths[ph]);
        end

        drain();
        repeat (LATENCY + 20) @(negedge aclk);
        if (pair_sb.errors == 0 && pair_sb.want_w.size() == 0)
            $display("sph_cubic_kernel_and_gradient test passed");
        else
            $display("sph_cubic_kernel_and_gradient test failed");
        $finish;
    end
endmodule
